// File: rtl/core/hts_pkg.sv
// ----------------------------------------------------------------------------
// hts_pkg
// Shared types, constants and control bundles of the terrain height sampler.
// ----------------------------------------------------------------------------
package hts_pkg;

  localparam int GRID_MAX_DEF = 64;

  localparam int DATA_W     = 32;
  localparam int SPACING_W  = 31;
  localparam int COUNT_W    = 7;
  localparam int VIDX_W     = 7;
  localparam int CFG_IDX_W  = 2;

  // Sequential divider: 64-bit dividend, 31-bit divisor, 33 quotient bits.
  localparam int DIVIDEND_W = 64;
  localparam int QUOT_W     = 33;
  localparam int DIV_STEPS  = QUOT_W;
  localparam int PROD_W     = 63;

  localparam logic [SPACING_W-1:0] SPACING_RESET = 31'd65536;
  localparam logic [COUNT_W-1:0]   CELLS_RESET   = 7'd64;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SPACING = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_X = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_Y = 2'd2;

  // Item opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic                     op;
    logic [VIDX_W-1:0]        column;
    logic [VIDX_W-1:0]        row;
    logic signed [DATA_W-1:0] height_in;
    logic signed [DATA_W-1:0] x_coord;
    logic signed [DATA_W-1:0] y_coord;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] height_out;
    logic signed [DATA_W-1:0] slope_x;
    logic signed [DATA_W-1:0] slope_y;
    logic signed [DATA_W-1:0] slope_z;
    logic                     in_cell;
    logic                     inside_map;
  } out_item_t;

  typedef enum logic [1:0] {
    DIV_X = 2'd0,
    DIV_Y = 2'd1,
    DIV_P = 2'd2
  } div_src_t;

  typedef enum logic [1:0] {
    VTX_BASE = 2'd0,
    VTX_A1   = 2'd1,
    VTX_A2   = 2'd2
  } vtx_sel_t;

  typedef struct packed {
    logic     accept;
    logic     check;
    logic     div_start;
    div_src_t div_src;
    logic     cap_x;
    logic     cap_y;
    logic     classify;
    vtx_sel_t rd_sel;
    logic     cap_b;
    logic     cap_a1;
    logic     cap_a2;
    logic     mul_en;
    logic     mul_second;
    logic     cap_t1;
    logic     cap_t2;
    logic     finish;
  } cmd_t;

  typedef struct packed {
    logic is_query;
    logic pre_ok;
    logic hit;
    logic div_done;
  } status_t;

endpackage

// File: rtl/core/heightmap_triangle_sampler_unit.sv
// ----------------------------------------------------------------------------
// heightmap_triangle_sampler_unit
// Terrain height sampler on a regular grid of vertex heights.
// ----------------------------------------------------------------------------
// A write item stores one vertex height and gives no result. A query item
// finds the grid cell that strictly holds (x, y), picks the lower or upper
// triangle from the in-cell offsets and returns the interpolated height,
// the slope pair and the two position flags. Its divisions go through one
// restoring divider that yields one quotient bit per cycle: the x and y
// cell searches and the two weighted terms. A query also takes the bounds
// check, the cell classification, three vertex reads and the two
// multiplies. A point with a negative or zero coordinate, or with zero
// spacing, goes from the bounds check straight to the result; one on a grid
// line or beyond the map goes to the result after the cell searches.
// Once the result is registered, the block is idle and ready for the next
// item. The block takes one item at a time; a finished result sits in an
// output register, so the next item is accepted while it waits, and a query
// that finishes while that register is still full holds until it is taken.
// The vertex store has no reset: read only vertices written since reset.
// ----------------------------------------------------------------------------
module heightmap_triangle_sampler_unit
  import hts_pkg::*;
#(
  parameter int GRID_MAX = GRID_MAX_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration write port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SPACING_W-1:0] cfg_data,
  // input items
  input  logic                 item_valid,
  output logic                 item_ready,
  input  in_item_t             item,
  // result items
  output logic                 result_valid,
  input  logic                 result_ready,
  output out_item_t            result
);

  cmd_t    cmd;
  status_t status;

  // Sequencer: owns the handshake and the step order
  hts_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .status       (status),
    .cmd          (cmd)
  );

  // Datapath: registers, vertex store, divider and result register
  hts_datapath #(
    .GRID_MAX (GRID_MAX)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item),
    .cmd       (cmd),
    .status    (status),
    .result    (result)
  );

endmodule

// File: rtl/core/hts_divider.sv
// ----------------------------------------------------------------------------
// hts_divider
// Restoring divider, one quotient bit per cycle, unsigned operands.
// ----------------------------------------------------------------------------
module hts_divider
  import hts_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [SPACING_W-1:0]  divisor,
  output logic                  done,
  output logic [QUOT_W-1:0]     quotient,
  output logic [SPACING_W-1:0]  remainder
);

  localparam int CNT_W = $clog2(DIV_STEPS + 1);

  logic                 busy;
  logic [CNT_W-1:0]     cnt;
  logic [SPACING_W-1:0] rem;
  logic [QUOT_W-1:0]    work;
  logic [SPACING_W:0]   trial;
  logic [SPACING_W:0]   diff;
  logic                 ge;

  // Caller guarantees the upper dividend bits are below the divisor.
  assign trial = {rem, work[QUOT_W-1]};
  assign ge    = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIV_STEPS);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= dividend[DIVIDEND_W-1:QUOT_W];
      work <= dividend[QUOT_W-1:0];
    end else if (busy) begin
      rem  <= ge ? diff[SPACING_W-1:0] : trial[SPACING_W-1:0];
      work <= {work[QUOT_W-2:0], ge};
    end
  end

  assign quotient  = work;
  assign remainder = rem;

endmodule

// File: rtl/core/hts_datapath.sv
// ----------------------------------------------------------------------------
// hts_datapath
// Configuration, vertex store, cell search, interpolation and result register.
// ----------------------------------------------------------------------------
module hts_datapath
  import hts_pkg::*;
#(
  parameter int GRID_MAX = GRID_MAX_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SPACING_W-1:0] cfg_data,
  input  in_item_t             item,
  input  cmd_t                 cmd,
  output status_t              status,
  output out_item_t            result
);

  localparam int STRIDE = GRID_MAX + 1;
  localparam int DEPTH  = STRIDE * STRIDE;
  localparam int AW     = $clog2(DEPTH);
  localparam int IW     = $clog2(STRIDE);
  localparam int BW     = SPACING_W + IW;

  localparam logic signed [DATA_W+2:0] SAT_MAX = 35'sd2147483647;
  localparam logic signed [DATA_W+2:0] SAT_MIN = -35'sd2147483648;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [DATA_W+2:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > SAT_MAX) begin
      r = SAT_MAX[DATA_W-1:0];
    end else if (v < SAT_MIN) begin
      r = SAT_MIN[DATA_W-1:0];
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

  logic [SPACING_W-1:0] spacing;
  logic [COUNT_W-1:0]   cells_x;
  logic [COUNT_W-1:0]   cells_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      spacing <= SPACING_RESET;
      cells_x <= CELLS_RESET;
      cells_y <= CELLS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SPACING: spacing <= cfg_data;
        REG_CELLS_X: cells_x <= cfg_data[COUNT_W-1:0];
        REG_CELLS_Y: cells_y <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Cell counts clamp to the grid size
  logic [IW-1:0] eff_x;
  logic [IW-1:0] eff_y;
  assign eff_x = (32'(cells_x) > 32'(GRID_MAX)) ? IW'(GRID_MAX) : IW'(cells_x);
  assign eff_y = (32'(cells_y) > 32'(GRID_MAX)) ? IW'(GRID_MAX) : IW'(cells_y);

  logic signed [DATA_W-1:0] x_reg;
  logic signed [DATA_W-1:0] y_reg;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      x_reg <= item.x_coord;
      y_reg <= item.y_coord;
    end
  end

  // Vertex store
  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data;
  logic [AW-1:0]     wr_addr;
  logic [AW-1:0]     rd_addr;
  logic              wr_en;

  assign wr_en = cmd.accept && (item.op == OP_WRITE)
                 && (32'(item.column) <= 32'(GRID_MAX))
                 && (32'(item.row) <= 32'(GRID_MAX));
  assign wr_addr = AW'(item.row) * AW'(STRIDE) + AW'(item.column);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= item.height_in;
    end
    rd_data <= mem[rd_addr];
  end

  // Bounds and cell search state
  logic                 x_pos, y_pos, x_lt, y_lt;
  logic [BW-1:0]        bound_x, bound_y;
  logic                 in_map;
  logic                 hit_x, hit_y;
  logic [IW-1:0]        ix, jy;
  logic [SPACING_W-1:0] rx, ry;
  logic                 case_a;

  assign x_pos   = !x_reg[DATA_W-1] && (x_reg != '0);
  assign y_pos   = !y_reg[DATA_W-1] && (y_reg != '0);
  assign bound_x = BW'(eff_x) * BW'(spacing);
  assign bound_y = BW'(eff_y) * BW'(spacing);
  assign x_lt    = BW'(x_reg[DATA_W-2:0]) < bound_x;
  assign y_lt    = BW'(y_reg[DATA_W-2:0]) < bound_y;

  // Divider
  logic                  div_done;
  logic [QUOT_W-1:0]     quot;
  logic [SPACING_W-1:0]  rem;
  logic [DIVIDEND_W-1:0] dividend;
  logic [PROD_W-1:0]     prod;
  logic                  prod_neg;

  always_comb begin
    case (cmd.div_src)
      DIV_X:   dividend = DIVIDEND_W'(x_reg[DATA_W-2:0]);
      DIV_Y:   dividend = DIVIDEND_W'(y_reg[DATA_W-2:0]);
      DIV_P:   dividend = DIVIDEND_W'(prod);
      default: dividend = '0;
    endcase
  end

  hts_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (dividend),
    .divisor   (spacing),
    .done      (div_done),
    .quotient  (quot),
    .remainder (rem)
  );

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      in_map <= x_pos && y_pos && x_lt && y_lt;
      hit_x  <= 1'b0;
      hit_y  <= 1'b0;
    end
    if (cmd.cap_x) begin
      hit_x <= (rem != '0) && (quot < QUOT_W'(eff_x));
      ix    <= quot[IW-1:0];
      rx    <= rem;
    end
    if (cmd.cap_y) begin
      hit_y <= (rem != '0) && (quot < QUOT_W'(eff_y));
      jy    <= quot[IW-1:0];
      ry    <= rem;
    end
    if (cmd.classify) begin
      case_a <= rx > ry;
    end
  end

  // Vertex addressing: lower triangle when dx > dy
  logic [IW-1:0] ip1, jp1, rc, rr;
  assign ip1 = ix + IW'(1);
  assign jp1 = jy + IW'(1);

  always_comb begin
    case (cmd.rd_sel)
      VTX_BASE: begin
        rc = case_a ? ip1 : ix;
        rr = case_a ? jy  : jp1;
      end
      VTX_A1: begin
        rc = case_a ? ix : ip1;
        rr = case_a ? jy : jp1;
      end
      VTX_A2: begin
        rc = case_a ? ip1 : ix;
        rr = case_a ? jp1 : jy;
      end
      default: begin
        rc = ix;
        rr = jy;
      end
    endcase
  end

  assign rd_addr = AW'(rr) * AW'(STRIDE) + AW'(rc);

  logic signed [DATA_W-1:0] hb, ha1, ha2;
  logic signed [DATA_W:0]   d1, d2, d_sel, d_mag;
  logic [SPACING_W-1:0]     w_sel;

  always_ff @(posedge clk) begin
    if (cmd.cap_b)  hb  <= rd_data;
    if (cmd.cap_a1) ha1 <= rd_data;
    if (cmd.cap_a2) ha2 <= rd_data;
  end

  assign d1 = (DATA_W+1)'(ha1) - (DATA_W+1)'(hb);
  assign d2 = (DATA_W+1)'(ha2) - (DATA_W+1)'(hb);

  always_comb begin
    if (cmd.mul_second) begin
      d_sel = d2;
      w_sel = case_a ? ry : spacing - ry;
    end else begin
      d_sel = d1;
      w_sel = case_a ? spacing - rx : rx;
    end
  end

  assign d_mag = d_sel[DATA_W] ? -d_sel : d_sel;

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod     <= PROD_W'(d_mag[DATA_W-1:0]) * PROD_W'(w_sel);
      prod_neg <= d_sel[DATA_W];
    end
  end

  // Signed terms, truncated toward zero
  logic signed [QUOT_W:0] q_s, t1, t2;
  assign q_s = $signed({1'b0, quot});

  always_ff @(posedge clk) begin
    if (cmd.cap_t1) t1 <= prod_neg ? -q_s : q_s;
    if (cmd.cap_t2) t2 <= prod_neg ? -q_s : q_s;
  end

  logic signed [DATA_W+2:0] h_sum, sx_w, sy_w;
  logic                     hit;

  assign hit   = hit_x && hit_y;
  assign h_sum = (DATA_W+3)'(hb) + (DATA_W+3)'(t1) + (DATA_W+3)'(t2);
  assign sx_w  = case_a ? (DATA_W+3)'(d1) : -(DATA_W+3)'(d1);
  assign sy_w  = case_a ? -(DATA_W+3)'(d2) : (DATA_W+3)'(d2);

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      result.height_out <= hit ? sat32(h_sum) : '0;
      result.slope_x    <= hit ? sat32(sx_w) : '0;
      result.slope_y    <= hit ? sat32(sy_w) : '0;
      result.slope_z    <= '0;
      result.in_cell    <= hit;
      result.inside_map <= in_map;
    end
  end

  assign status.is_query = (item.op == OP_QUERY);
  assign status.pre_ok   = x_pos && y_pos && (spacing != '0);
  assign status.hit      = hit;
  assign status.div_done = div_done;

endmodule

// File: rtl/core/hts_ctrl.sv
// ----------------------------------------------------------------------------
// hts_ctrl
// Sequencer for one query: bounds, two cell divisions, three vertex reads,
// two weighted terms, then the result hand-off.
// ----------------------------------------------------------------------------
module hts_ctrl
  import hts_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  output logic    result_valid,
  input  logic    result_ready,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [17:0] {
    S_IDLE  = 18'h00001,
    S_CHECK = 18'h00002,
    S_LDX   = 18'h00004,
    S_DIVX  = 18'h00008,
    S_LDY   = 18'h00010,
    S_DIVY  = 18'h00020,
    S_CELL  = 18'h00040,
    S_RD0   = 18'h00080,
    S_RD1   = 18'h00100,
    S_RD2   = 18'h00200,
    S_RD3   = 18'h00400,
    S_MUL1  = 18'h00800,
    S_LD1   = 18'h01000,
    S_DIV1  = 18'h02000,
    S_MUL2  = 18'h04000,
    S_LD2   = 18'h08000,
    S_DIV2  = 18'h10000,
    S_DONE  = 18'h20000
  } state_t;

  state_t state, state_next;

  assign item_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        cmd.accept = item_valid;
        if (item_valid && status.is_query) state_next = S_CHECK;
      end
      S_CHECK: begin
        cmd.check  = 1'b1;
        state_next = status.pre_ok ? S_LDX : S_DONE;
      end
      S_LDX: begin
        cmd.div_start = 1'b1;
        cmd.div_src   = DIV_X;
        state_next    = S_DIVX;
      end
      S_DIVX: begin
        cmd.div_src = DIV_X;
        if (status.div_done) begin
          cmd.cap_x  = 1'b1;
          state_next = S_LDY;
        end
      end
      S_LDY: begin
        cmd.div_start = 1'b1;
        cmd.div_src   = DIV_Y;
        state_next    = S_DIVY;
      end
      S_DIVY: begin
        cmd.div_src = DIV_Y;
        if (status.div_done) begin
          cmd.cap_y  = 1'b1;
          state_next = S_CELL;
        end
      end
      S_CELL: begin
        cmd.classify = 1'b1;
        state_next   = status.hit ? S_RD0 : S_DONE;
      end
      S_RD0: begin
        cmd.rd_sel = VTX_BASE;
        state_next = S_RD1;
      end
      S_RD1: begin
        cmd.rd_sel = VTX_A1;
        cmd.cap_b  = 1'b1;
        state_next = S_RD2;
      end
      S_RD2: begin
        cmd.rd_sel = VTX_A2;
        cmd.cap_a1 = 1'b1;
        state_next = S_RD3;
      end
      S_RD3: begin
        cmd.cap_a2 = 1'b1;
        state_next = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul_en = 1'b1;
        state_next = S_LD1;
      end
      S_LD1: begin
        cmd.div_start = 1'b1;
        cmd.div_src   = DIV_P;
        state_next    = S_DIV1;
      end
      S_DIV1: begin
        cmd.div_src = DIV_P;
        if (status.div_done) begin
          cmd.cap_t1 = 1'b1;
          state_next = S_MUL2;
        end
      end
      S_MUL2: begin
        cmd.mul_en     = 1'b1;
        cmd.mul_second = 1'b1;
        state_next     = S_LD2;
      end
      S_LD2: begin
        cmd.div_start = 1'b1;
        cmd.div_src   = DIV_P;
        state_next    = S_DIV2;
      end
      S_DIV2: begin
        cmd.div_src = DIV_P;
        if (status.div_done) begin
          cmd.cap_t2 = 1'b1;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        // Hold until the result register is free
        if (!result_valid || result_ready) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/core/hts_checker.sv
// ----------------------------------------------------------------------------
// hts_checker
// Port-level checks of the terrain height sampler.
// ----------------------------------------------------------------------------
module hts_checker
  import hts_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 cfg_we,
  input logic [CFG_IDX_W-1:0] cfg_index,
  input logic [SPACING_W-1:0] cfg_data,
  input logic                 item_valid,
  input logic                 item_ready,
  input in_item_t             item,
  input logic                 result_valid,
  input logic                 result_ready,
  input out_item_t            result
);

  // A stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result dropped or changed while stalled");

  // After a query is accepted, the block is not ready in the next cycle
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && (item.op == OP_QUERY) |=> !item_ready)
    else $error("item taken right after a query");

  a_slope_z: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.slope_z == '0)
    else $error("third slope component not zero");

  a_cell_in_map: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.in_cell |-> result.inside_map)
    else $error("point in a cell but outside the map");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.in_cell |->
      (result.height_out == '0) && (result.slope_x == '0) && (result.slope_y == '0))
    else $error("miss result carries nonzero height or slope");

endmodule

bind heightmap_triangle_sampler_unit hts_checker u_hts_checker (.*);
